// ===== design/pdct_pkg.sv =====
`timescale 1ns / 1ps

package pdct_pkg;

	localparam int CH_W       = 10;
	localparam int START_W    = 44;
	localparam int LOCAL_W    = 32;
	localparam int E_W        = 20;
	localparam int T_W        = 45;
	localparam int WIN_W      = 32;
	localparam int SINCE_W    = 33;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_GOOD   = 21;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW = 3'd0,
		CFG_NAT_LO = 3'd1,
		CFG_NAT_HI = 3'd2,
		CFG_ENR_LO = 3'd3,
		CFG_ENR_HI = 3'd4
	} cfg_idx_t;

	localparam logic [WIN_W-1:0] WINDOW_RST = 32'd4062600;
	localparam logic [E_W-1:0]   NAT_LO_RST = 20'd9968;
	localparam logic [E_W-1:0]   NAT_HI_RST = 20'd10990;
	localparam logic [E_W-1:0]   ENR_LO_RST = 20'd9615;
	localparam logic [E_W-1:0]   ENR_HI_RST = 20'd11455;

	typedef struct packed {
		logic [CH_W-1:0] chan;
		logic            enriched;
	} good_entry_t;

	localparam good_entry_t GOOD_TABLE [NUM_GOOD] = '{
		'{10'd646, 1'b0}, '{10'd644, 1'b1}, '{10'd642, 1'b1}, '{10'd626, 1'b1},
		'{10'd624, 1'b1}, '{10'd674, 1'b1}, '{10'd576, 1'b1}, '{10'd692, 1'b1},
		'{10'd690, 1'b1}, '{10'd688, 1'b1}, '{10'd640, 1'b1}, '{10'd610, 1'b1},
		'{10'd664, 1'b0}, '{10'd662, 1'b1}, '{10'd656, 1'b1}, '{10'd696, 1'b1},
		'{10'd608, 1'b0}, '{10'd598, 1'b0}, '{10'd600, 1'b0}, '{10'd594, 1'b0},
		'{10'd592, 1'b0}
	};

	typedef struct packed {
		logic good;
		logic enriched;
	} chan_class_t;

	function automatic chan_class_t classify(input logic [CH_W-1:0] ch);
		chan_class_t c;
		c = '0;
		for (int i = 0; i < NUM_GOOD; i++) begin
			if (GOOD_TABLE[i].chan == ch) begin
				c.good     = 1'b1;
				c.enriched = GOOD_TABLE[i].enriched;
			end
		end
		return c;
	endfunction

	typedef struct packed {
		logic capture;
		logic eval;
		logic push;
		logic scan;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_status_t;

endpackage

// ===== design/prompt_delayed_coincidence_tagger.sv =====
`timescale 1ns / 1ps
// each accepted hit is captured, evaluated and pushed into the ring if it is a prompt;
// for a good hit the n stored prompts (n at most PROMPT_DEPTH) are then scanned, one entry
// per cycle, and in_stall holds off the next hit until the result register loads.
// a finished result waits in the output register while the next hit is taken in
// reset (arst_n low): control, ring pointer, fill count and configuration registers return to defaults
// ring contents are not cleared; entries beyond the fill count are never read

module prompt_delayed_coincidence_tagger #(
	parameter int PROMPT_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pdct_pkg::CH_W-1:0]           channel_id,
	input  logic [pdct_pkg::START_W-1:0]        run_start_ms,
	input  logic [pdct_pkg::LOCAL_W-1:0]        local_ms,
	input  logic [pdct_pkg::E_W-1:0]            energy_ev,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                good_hit,
	output logic                                prompt_flag,
	output logic                                delayed_same_flag,
	output logic                                delayed_other_flag,
	output logic signed [pdct_pkg::SINCE_W-1:0] time_since_ms,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pdct_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdct_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pdct_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	pdct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.status   (status)
	);

	pdct_dp #(
		.PROMPT_DEPTH(PROMPT_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.channel_id        (channel_id),
		.run_start_ms      (run_start_ms),
		.local_ms          (local_ms),
		.energy_ev         (energy_ev),
		.good_hit          (good_hit),
		.prompt_flag       (prompt_flag),
		.delayed_same_flag (delayed_same_flag),
		.delayed_other_flag(delayed_other_flag),
		.time_since_ms     (time_since_ms)
	);

endmodule

// ===== design/pdct_ram.sv =====
`timescale 1ns / 1ps

module pdct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/pdct_ctrl.sv =====
`timescale 1ns / 1ps

module pdct_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pdct_pkg::dp_cmd_t    cmd,
	input  pdct_pkg::dp_status_t status
);
	import pdct_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_PUSH = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EVAL))
		else $error("accepted beat did not start evaluation");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside done");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=> (state_q == ST_DONE))
		else $error("pending result overwritten");

endmodule

// ===== design/pdct_dp.sv =====
`timescale 1ns / 1ps

module pdct_dp #(
	parameter int PROMPT_DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pdct_pkg::dp_cmd_t                      cmd,
	output pdct_pkg::dp_status_t                   status,
	input  logic                                   cfg_we,
	input  logic [pdct_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pdct_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic [pdct_pkg::CH_W-1:0]              channel_id,
	input  logic [pdct_pkg::START_W-1:0]           run_start_ms,
	input  logic [pdct_pkg::LOCAL_W-1:0]           local_ms,
	input  logic [pdct_pkg::E_W-1:0]               energy_ev,
	output logic                                   good_hit,
	output logic                                   prompt_flag,
	output logic                                   delayed_same_flag,
	output logic                                   delayed_other_flag,
	output logic signed [pdct_pkg::SINCE_W-1:0]    time_since_ms
);
	import pdct_pkg::*;

	localparam int PTR_W = (PROMPT_DEPTH > 1) ? $clog2(PROMPT_DEPTH) : 1;
	localparam int CNT_W = $clog2(PROMPT_DEPTH + 1);
	localparam int RAM_W = CH_W + T_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PROMPT_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PROMPT_DEPTH);

	// configuration
	logic [WIN_W-1:0] win_q;
	logic [E_W-1:0]   nat_lo_q, nat_hi_q, enr_lo_q, enr_hi_q;

	// captured beat and evaluation
	logic [CH_W-1:0]    ch_q;
	logic [START_W-1:0] start_q;
	logic [LOCAL_W-1:0] local_q;
	logic [E_W-1:0]     energy_q;
	logic [T_W-1:0]     t_q;
	logic               good_q, prompt_q;

	// ring and scan
	logic [PTR_W-1:0] wp_q, wp_inc, wp_nx, oldest, scan_idx_q, idx_inc;
	logic [CNT_W-1:0] count_q, cnt_nx, scan_left_q;
	logic             rd_vld_s1;
	logic [RAM_W-1:0] rdata;
	logic             ram_we;

	// match accumulation and result
	logic               same_q, other_q, hit_q;
	logic [WIN_W-1:0]   since_q;
	logic               good_hit_q, prompt_flag_q, same_out_q, other_out_q;
	logic [SINCE_W-1:0] since_out_q;

	chan_class_t        cls;
	logic [E_W-1:0]     lo, hi;
	logic               is_prompt;
	logic [CH_W-1:0]    rd_ch;
	logic [T_W-1:0]     rd_t;
	logic [T_W:0]       diff;
	logic               match;

	assign cls       = classify(ch_q);
	assign lo        = cls.enriched ? enr_lo_q : nat_lo_q;
	assign hi        = cls.enriched ? enr_hi_q : nat_hi_q;
	assign is_prompt = cls.good && (energy_q > lo) && (energy_q < hi);

	assign wp_inc  = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign wp_nx   = prompt_q ? wp_inc : wp_q;
	assign cnt_nx  = (prompt_q && count_q != CNT_FULL) ? count_q + 1'b1 : count_q;
	assign oldest  = (cnt_nx == CNT_FULL) ? wp_nx : '0;
	assign idx_inc = (scan_idx_q == PTR_LAST) ? '0 : scan_idx_q + 1'b1;
	assign ram_we  = cmd.push && prompt_q;

	assign rd_ch = rdata[RAM_W-1 -: CH_W];
	assign rd_t  = rdata[T_W-1:0];
	assign diff  = {1'b0, t_q} - {1'b0, rd_t};
	assign match = !diff[T_W] && (diff[T_W-1:0] != '0)
		&& (diff[T_W-1:0] < {{(T_W - WIN_W){1'b0}}, win_q});

	assign status.scan_done = (scan_left_q == '0) && !rd_vld_s1;

	pdct_ram #(
		.WIDTH(RAM_W),
		.DEPTH(PROMPT_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata({ch_q, t_q}),
		.raddr(scan_idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= WINDOW_RST;
			nat_lo_q    <= NAT_LO_RST;
			nat_hi_q    <= NAT_HI_RST;
			enr_lo_q    <= ENR_LO_RST;
			enr_hi_q    <= ENR_HI_RST;
			wp_q        <= '0;
			count_q     <= '0;
			scan_left_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_WINDOW: win_q    <= cfg_data;
					CFG_NAT_LO: nat_lo_q <= cfg_data[E_W-1:0];
					CFG_NAT_HI: nat_hi_q <= cfg_data[E_W-1:0];
					CFG_ENR_LO: enr_lo_q <= cfg_data[E_W-1:0];
					CFG_ENR_HI: enr_hi_q <= cfg_data[E_W-1:0];
					default: ;
				endcase
			end
			if (cmd.push) begin
				wp_q        <= wp_nx;
				count_q     <= cnt_nx;
				scan_left_q <= good_q ? cnt_nx : '0;
				rd_vld_s1   <= 1'b0;
			end else if (cmd.scan && scan_left_q != '0) begin
				scan_left_q <= scan_left_q - 1'b1;
				rd_vld_s1   <= 1'b1;
			end else begin
				rd_vld_s1   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q     <= channel_id;
			start_q  <= run_start_ms;
			local_q  <= local_ms;
			energy_q <= energy_ev;
		end
		if (cmd.eval) begin
			t_q      <= {1'b0, start_q} + {{(T_W - LOCAL_W){1'b0}}, local_q};
			good_q   <= cls.good;
			prompt_q <= is_prompt;
		end
		if (cmd.push) begin
			scan_idx_q <= oldest;
			same_q     <= 1'b0;
			other_q    <= 1'b0;
			hit_q      <= 1'b0;
		end else if (cmd.scan && scan_left_q != '0) begin
			scan_idx_q <= idx_inc;
		end
		if (rd_vld_s1 && match) begin
			hit_q   <= 1'b1;
			since_q <= diff[WIN_W-1:0];
			if (rd_ch == ch_q) begin
				same_q <= 1'b1;
			end else begin
				other_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			good_hit_q    <= good_q;
			prompt_flag_q <= prompt_q;
			same_out_q    <= same_q;
			other_out_q   <= other_q;
			since_out_q   <= hit_q ? {1'b0, since_q} : '1;
		end
	end

	assign good_hit           = good_hit_q;
	assign prompt_flag        = prompt_flag_q;
	assign delayed_same_flag  = same_out_q;
	assign delayed_other_flag = other_out_q;
	assign time_since_ms      = since_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("prompt count beyond ring depth");

	a_ptr_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != CNT_FULL) |-> (CNT_W'(wp_q) == count_q))
		else $error("write pointer out of step with fill count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_left_q <= count_q)
		else $error("scan longer than stored prompts");

endmodule

// ===== verif/prompt_delayed_coincidence_tagger_tb.sv =====
`timescale 1ns / 1ps

module prompt_delayed_coincidence_tagger_tb;
	import pdct_pkg::*;

	localparam int RING_DEPTH    = 64;
	localparam int PHASES        = 8;
	localparam int PHASE_HITS    = 60;
	localparam int DRAIN_CYCLES  = RING_DEPTH + 8;
	localparam int LIMIT_CYCLES  = 500000;
	localparam int SHOWN_ERRORS  = 30;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef struct packed {
		logic [CH_W-1:0]    chan;
		logic [START_W-1:0] start;
		logic [LOCAL_W-1:0] loc;
		logic [E_W-1:0]     energy;
	} hit_t;

	typedef struct packed {
		logic                      good;
		logic                      prompt;
		logic                      same;
		logic                      other;
		logic signed [SINCE_W-1:0] since;
	} hit_tag_t;

	class coincidence_scoreboard;
		logic [CH_W-1:0] good_chan [NUM_GOOD] = '{
			10'd646, 10'd644, 10'd642, 10'd626, 10'd624, 10'd674, 10'd576,
			10'd692, 10'd690, 10'd688, 10'd640, 10'd610, 10'd664, 10'd662,
			10'd656, 10'd696, 10'd608, 10'd598, 10'd600, 10'd594, 10'd592
		};
		bit good_enr [NUM_GOOD] = '{
			1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
			1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
			1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
		};

		logic [WIN_W-1:0] window = WINDOW_RST;
		logic [E_W-1:0]   nat_lo = NAT_LO_RST;
		logic [E_W-1:0]   nat_hi = NAT_HI_RST;
		logic [E_W-1:0]   enr_lo = ENR_LO_RST;
		logic [E_W-1:0]   enr_hi = ENR_HI_RST;

		logic [CH_W-1:0] ring_chan [RING_DEPTH];
		logic [T_W-1:0]  ring_time [RING_DEPTH];
		int unsigned     wr_ptr = 0;
		int unsigned     fill   = 0;

		hit_tag_t    expected_tags [$];
		int unsigned mismatches = 0;
		int unsigned hits_seen  = 0;
		int unsigned tags_seen  = 0;
		int unsigned prompts    = 0;
		int unsigned same_cnt   = 0;
		int unsigned other_cnt  = 0;

		function bit [1:0] chan_kind(logic [CH_W-1:0] ch);
			bit [1:0] kind;
			kind = 2'b00;
			for (int i = 0; i < NUM_GOOD; i++)
				if (good_chan[i] == ch) kind = {1'b1, good_enr[i]};
			return kind;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_WINDOW: window = data;
				CFG_NAT_LO: nat_lo = data[E_W-1:0];
				CFG_NAT_HI: nat_hi = data[E_W-1:0];
				CFG_ENR_LO: enr_lo = data[E_W-1:0];
				CFG_ENR_HI: enr_hi = data[E_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_hit(hit_t h);
			hit_tag_t       tag;
			logic [T_W-1:0] t;
			logic [T_W-1:0] d;
			logic [E_W-1:0] lo;
			logic [E_W-1:0] hi;
			bit [1:0]       kind;
			int unsigned    idx;
			t = T_W'(h.start) + T_W'(h.loc);
			kind = chan_kind(h.chan);
			tag.good   = kind[1];
			tag.prompt = 1'b0;
			tag.same   = 1'b0;
			tag.other  = 1'b0;
			tag.since  = '1;
			if (kind[1]) begin
				lo = kind[0] ? enr_lo : nat_lo;
				hi = kind[0] ? enr_hi : nat_hi;
				if (h.energy > lo && h.energy < hi) begin
					ring_chan[wr_ptr] = h.chan;
					ring_time[wr_ptr] = t;
					wr_ptr = (wr_ptr + 1) % RING_DEPTH;
					if (fill < RING_DEPTH) fill++;
					tag.prompt = 1'b1;
					prompts++;
				end
				// oldest entry first, the last match sets the reported gap
				idx = (wr_ptr + RING_DEPTH - fill) % RING_DEPTH;
				for (int k = 0; k < fill; k++) begin
					if (t > ring_time[idx]) begin
						d = t - ring_time[idx];
						if (d < T_W'(window)) begin
							if (ring_chan[idx] == h.chan) tag.same = 1'b1;
							else tag.other = 1'b1;
							tag.since = d[SINCE_W-1:0];
						end
					end
					idx = (idx + 1) % RING_DEPTH;
				end
				if (tag.same) same_cnt++;
				if (tag.other) other_cnt++;
			end
			hits_seen++;
			expected_tags = {expected_tags, tag};
		endfunction

		task report_mismatch(string what, longint unsigned got, longint unsigned want);
			if (mismatches < SHOWN_ERRORS)
				$display("mismatch on result %0d, %s: got %0h expected %0h",
					tags_seen, what, got, want);
			mismatches++;
		endtask

		task check_tag(hit_tag_t got);
			hit_tag_t want;
			if (expected_tags.size() == 0) begin
				report_mismatch("result with no hit waiting", 64'd0, 64'd0);
				tags_seen++;
				return;
			end
			want = expected_tags.pop_front();
			if (got.good !== want.good)
				report_mismatch("good_hit", 64'(got.good), 64'(want.good));
			if (got.prompt !== want.prompt)
				report_mismatch("prompt_flag", 64'(got.prompt), 64'(want.prompt));
			if (got.same !== want.same)
				report_mismatch("delayed_same_flag", 64'(got.same), 64'(want.same));
			if (got.other !== want.other)
				report_mismatch("delayed_other_flag", 64'(got.other), 64'(want.other));
			if (got.since !== want.since)
				report_mismatch("time_since_ms", 64'(got.since), 64'(want.since));
			tags_seen++;
		endtask
	endclass

	logic                   clk;
	logic                   arst_n             = 1'b0;
	logic                   in_valid           = 1'b0;
	logic                   in_stall;
	logic [CH_W-1:0]        channel_id         = '0;
	logic [START_W-1:0]     run_start_ms       = '0;
	logic [LOCAL_W-1:0]     local_ms           = '0;
	logic [E_W-1:0]         energy_ev          = '0;
	logic                   out_valid;
	logic                   out_stall          = 1'b0;
	logic                   good_hit;
	logic                   prompt_flag;
	logic                   delayed_same_flag;
	logic                   delayed_other_flag;
	logic signed [SINCE_W-1:0] time_since_ms;
	logic                   cfg_valid          = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index          = '0;
	logic [CFG_DATA_W-1:0]  cfg_data           = '0;

	coincidence_scoreboard sb = new();

	int unsigned        send_idle_pct = 0;
	int unsigned        stall_pct     = 0;
	int unsigned        cycle_count   = 0;
	int unsigned        step_max      = 2;
	logic [START_W-1:0] run_base      = '0;
	logic [LOCAL_W-1:0] loc_now       = '0;

	hit_t     in_hit;
	hit_tag_t out_tag;

	assign in_hit  = {channel_id, run_start_ms, local_ms, energy_ev};
	assign out_tag = {good_hit, prompt_flag, delayed_same_flag, delayed_other_flag, time_since_ms};

	prompt_delayed_coincidence_tagger #(
		.PROMPT_DEPTH(RING_DEPTH)
	) i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout with %0d results outstanding", sb.expected_tags.size());
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_hit(in_hit);
			if (out_valid && !out_stall) sb.check_tag(out_tag);
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	task send_hit(hit_t h);
		int unsigned gap;
		gap = 0;
		if (send_idle_pct != 0) begin
			if ($urandom_range(0, 99) < 4) gap = $urandom_range(10, 80);
			else while ($urandom_range(0, 99) < send_idle_pct) gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		channel_id   <= h.chan;
		run_start_ms <= h.start;
		local_ms     <= h.loc;
		energy_ev    <= h.energy;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task send_fields(int ch, logic [START_W-1:0] start, logic [LOCAL_W-1:0] loc, int e);
		hit_t h;
		h.chan   = CH_W'(ch);
		h.start  = start;
		h.loc    = loc;
		h.energy = E_W'(e);
		send_hit(h);
	endtask

	task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task drain_results;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_tags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task configure_phase(int ph);
		logic [E_W-1:0] lo;
		case (ph)
			0: begin
				write_cfg(CFG_WINDOW, 32'd20000);
				write_cfg(CFG_NAT_LO, 32'd100);
				write_cfg(CFG_NAT_HI, 32'd60000);
				write_cfg(CFG_ENR_LO, 32'd50000);
				write_cfg(CFG_ENR_HI, 32'd900000);
			end
			1: begin
				write_cfg(CFG_WINDOW, 32'd0);
				write_cfg(CFG_NAT_LO, 32'd0);
				write_cfg(CFG_NAT_HI, 32'hFFFFF);
				write_cfg(CFG_ENR_LO, 32'd0);
				write_cfg(CFG_ENR_HI, 32'hFFFFF);
			end
			2: begin
				// empty and inverted energy windows, widest correlation window
				write_cfg(CFG_WINDOW, 32'hFFFF_FFFF);
				write_cfg(CFG_NAT_LO, 32'd5000);
				write_cfg(CFG_NAT_HI, 32'd5001);
				write_cfg(CFG_ENR_LO, 32'hFFFFF);
				write_cfg(CFG_ENR_HI, 32'd0);
			end
			3: begin
				write_cfg(CFG_WINDOW, 32'd2);
				write_cfg(CFG_NAT_LO, 32'hFFFFE);
				write_cfg(CFG_NAT_HI, 32'hFFFFF);
				write_cfg(CFG_ENR_LO, 32'd0);
				write_cfg(CFG_ENR_HI, 32'd2);
			end
			4: begin
				write_cfg(CFG_SPARE, $urandom);
				write_cfg(CFG_ENR_HI, CFG_DATA_W'(ENR_HI_RST));
				write_cfg(CFG_ENR_LO, CFG_DATA_W'(ENR_LO_RST));
				write_cfg(CFG_NAT_HI, CFG_DATA_W'(NAT_HI_RST));
				write_cfg(CFG_NAT_LO, CFG_DATA_W'(NAT_LO_RST));
				write_cfg(CFG_WINDOW, WINDOW_RST);
			end
			default: begin
				if ($urandom_range(0, 1) == 0) write_cfg(CFG_WINDOW, $urandom_range(0, 200000));
				else write_cfg(CFG_WINDOW, $urandom);
				lo = E_W'($urandom);
				write_cfg(CFG_NAT_LO, CFG_DATA_W'(lo));
				write_cfg(CFG_NAT_HI, CFG_DATA_W'(E_W'(lo + $urandom_range(0, 300000))));
				lo = E_W'($urandom);
				write_cfg(CFG_ENR_LO, CFG_DATA_W'(lo));
				write_cfg(CFG_ENR_HI, CFG_DATA_W'(E_W'(lo + $urandom_range(0, 300000))));
			end
		endcase
		cfg_valid <= 1'b0;
		step_max = sb.window / 6 + 2;
	endtask

	function automatic hit_t next_hit();
		hit_t           h;
		int unsigned    r;
		logic [LOCAL_W:0] sum;
		logic [E_W-1:0] lo;
		logic [E_W-1:0] hi;
		bit [1:0]       kind;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			run_base = START_W'({$urandom, $urandom});
			loc_now  = $urandom_range(0, 1000);
		end else if (r < 7) begin
			loc_now = $urandom;
		end else if (r < 12) begin
			loc_now = (loc_now > step_max) ? loc_now - $urandom_range(0, step_max) : '0;
		end else if (r >= 17) begin
			sum = {1'b0, loc_now} + $urandom_range(1, step_max);
			// carry into the run start so the hit time stays continuous
			if (sum[LOCAL_W]) begin
				run_base = run_base + START_W'(32'h8000_0000);
				sum      = sum - 33'h8000_0000;
			end
			loc_now = sum[LOCAL_W-1:0];
		end
		if ($urandom_range(0, 99) < 80) h.chan = sb.good_chan[$urandom_range(0, NUM_GOOD - 1)];
		else h.chan = CH_W'($urandom);
		kind = sb.chan_kind(h.chan);
		lo = kind[0] ? sb.enr_lo : sb.nat_lo;
		hi = kind[0] ? sb.enr_hi : sb.nat_hi;
		r = $urandom_range(0, 99);
		if (r < 45 && {1'b0, hi} > {1'b0, lo} + 21'd1) begin
			h.energy = E_W'($urandom_range(lo + 1, hi - 1));
		end else if (r < 65) begin
			case ($urandom_range(0, 3))
				0: h.energy = lo;
				1: h.energy = lo + 1'b1;
				2: h.energy = hi - 1'b1;
				default: h.energy = hi;
			endcase
		end else begin
			h.energy = E_W'($urandom);
		end
		h.start = run_base;
		h.loc   = loc_now;
		return h;
	endfunction

	initial begin
		logic [START_W-1:0] s0;
		s0 = 44'd100000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed hits on the reset settings
		send_fields(0, '0, '0, 0);
		send_fields(1023, '1, '1, 20'hFFFFF);
		send_fields(646, s0, 32'd1000, 9969);
		send_fields(664, s0, 32'd1000, 10000);
		send_fields(664, s0, 32'd1500, 9968);
		send_fields(646, s0, 32'd2000, 10989);
		send_fields(646, s0, 32'd2500, 10990);
		send_fields(644, s0, 32'd3000, 9616);
		send_fields(642, s0, 32'd3000, 9615);
		send_fields(656, s0, 32'd3500, 11454);
		send_fields(696, s0, 32'd3600, 11455);
		send_fields(645, s0, 32'd3700, 10000);
		send_fields(646, s0, 32'd500, 10000);
		send_fields(592, s0, 32'd1000 + WINDOW_RST, 10000);
		send_fields(592, s0, 32'd999 + WINDOW_RST, 0);
		send_fields(608, s0, 32'd1001 + WINDOW_RST, 20'hFFFFF);
		send_fields(674, '0, '0, 20'hFFFFF);
		send_fields(610, '1, '1, 10000);
		send_fields(690, '1, '1, 10000);
		send_fields(610, '1, 32'hFFFF_FFFE, 10500);
		drain_results();

		run_base = s0;
		loc_now  = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			configure_phase(ph);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 52; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 52; end
				default: begin send_idle_pct = 38; stall_pct = 38; end
			endcase
			repeat (PHASE_HITS) send_hit(next_hit());
			drain_results();
		end

		$display("%0d hits, %0d register sets: %0d prompts, %0d same and %0d other coincidences",
			sb.hits_seen, PHASES + 1, sb.prompts, sb.same_cnt, sb.other_cnt);
		$display("%0d results checked, %0d mismatches", sb.tags_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_tags.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/pdct_pkg.sv
design/pdct_ram.sv
design/pdct_ctrl.sv
design/pdct_dp.sv
design/prompt_delayed_coincidence_tagger.sv
verif/prompt_delayed_coincidence_tagger_tb.sv
